// File: rtl/sdef_pkg.sv
// shared types, constants and helpers for the server-sent-event data framer
`timescale 1ns / 1ps
`default_nettype none
package sdef_pkg;

  localparam int unsigned LEN_W = 21;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] LIMIT_RESET = 21'd262144;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [2:0] TAG_LEN = 3'd5;

  // line modes
  localparam logic [1:0] MODE_PREFIX = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_IGNORE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_EOE  = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  // register indexes
  localparam logic [0:0] REG_BYTE_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  // results caused by one beat
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } step_out_t;

  // expected characters of the "data:" prefix
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h64;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sse_data_event_framer.sv
// top level of the server-sent-event data framer with its register port
//
//  channel | direction | ports                          | beat when
//  in      | input     | in_data_byte                   | in_valid && !in_stall
//  out     | output    | out_kind, out_byte             | out_valid && !out_stall
//  cfg     | apb       | psel penable pwrite paddr ...  | psel && penable && pwrite
//
// one byte per cycle unless in_stall; each byte is handled in the cycle it is taken and its
// results land in a four-entry queue ahead of the output port
// a byte may yield two results, so in_stall rises while fewer than two slots are free
// synchronous active-low reset clears line, event and queue state; byte_limit resets to 262144
`timescale 1ns / 1ps
`default_nettype none
module sse_data_event_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [sdef_pkg::LEN_W-1:0] byte_limit_r;
  logic                       room2;
  logic                       take;
  logic                       reg_hit;
  sdef_pkg::step_out_t        step;

  assign pready   = 1'b1;
  assign reg_hit  = (paddr[2] == sdef_pkg::REG_BYTE_LIMIT) && (paddr[1:0] == 2'b00);
  assign prdata   = reg_hit ? {{(32-sdef_pkg::LEN_W){1'b0}}, byte_limit_r} : 32'h0;
  assign in_stall = !room2;
  assign take     = in_valid && room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= sdef_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      byte_limit_r <= pwdata[sdef_pkg::LEN_W-1:0];
    end
  end

  sdef_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_data_byte),
    .byte_limit (byte_limit_r),
    .step       (step)
  );

  sdef_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte)
  );

endmodule
`default_nettype wire

// File: rtl/sdef_parser.sv
// per-byte line and event state with the limit check
`timescale 1ns / 1ps
`default_nettype none
module sdef_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic [7:0]                 data_byte,
  input  wire logic [sdef_pkg::LEN_W-1:0] byte_limit,
  output sdef_pkg::step_out_t             step
);

  logic [1:0]                 line_mode_r, line_mode_nxt;
  logic [2:0]                 prefix_matched_r, prefix_matched_nxt;
  logic                       space_checked_r, space_checked_nxt;
  logic                       held_return_r, held_return_nxt;
  logic                       event_nonempty_r, event_nonempty_nxt;
  logic [sdef_pkg::LEN_W-1:0] line_length_r, line_length_nxt;
  logic [sdef_pkg::LEN_W-1:0] event_length_r, event_length_nxt;
  logic                       stopped_r, stopped_nxt;

  logic [sdef_pkg::LEN_W-1:0] line_inc;
  logic [sdef_pkg::LEN_W:0]   total;
  logic [sdef_pkg::LEN_W:0]   ev_sum;
  logic [1:0]                 n_data;
  sdef_pkg::res_t             r0, r1;
  logic [1:0]                 n_res;

  always_comb begin
    line_inc = (line_length_r < sdef_pkg::LEN_MAX) ? line_length_r + 1'b1 : line_length_r;
    total = {1'b0, line_inc} + {1'b0, event_length_r};

    line_mode_nxt      = line_mode_r;
    prefix_matched_nxt = prefix_matched_r;
    space_checked_nxt  = space_checked_r;
    held_return_nxt    = held_return_r;
    event_nonempty_nxt = event_nonempty_r;
    line_length_nxt    = line_length_r;
    stopped_nxt        = stopped_r;
    n_data = 2'd0;
    n_res  = 2'd0;
    r0 = '{kind: sdef_pkg::KIND_DATA, data: 8'h00};
    r1 = '{kind: sdef_pkg::KIND_DATA, data: 8'h00};

    if (!stopped_r) begin
      line_length_nxt = line_inc;
      if (total > {1'b0, byte_limit}) begin
        stopped_nxt = 1'b1;
        r0 = '{kind: sdef_pkg::KIND_OVF, data: 8'h00};
        n_res = 2'd1;
      end else if (data_byte == sdef_pkg::CH_LF) begin
        if (line_mode_r == sdef_pkg::MODE_PREFIX && prefix_matched_r == 3'd0 &&
            event_nonempty_r) begin
          r0 = '{kind: sdef_pkg::KIND_EOE, data: 8'h00};
          n_res = 2'd1;
          event_nonempty_nxt = 1'b0;
        end
        line_mode_nxt      = sdef_pkg::MODE_PREFIX;
        prefix_matched_nxt = 3'd0;
        space_checked_nxt  = 1'b0;
        held_return_nxt    = 1'b0;
        line_length_nxt    = '0;
      end else if (line_mode_r == sdef_pkg::MODE_PREFIX) begin
        if (held_return_r) begin
          line_mode_nxt   = sdef_pkg::MODE_IGNORE;
          held_return_nxt = 1'b0;
        end else if (data_byte == sdef_pkg::CH_CR && prefix_matched_r == 3'd0) begin
          held_return_nxt = 1'b1;
        end else if (prefix_matched_r < sdef_pkg::TAG_LEN &&
                     data_byte == sdef_pkg::tag_char(prefix_matched_r)) begin
          prefix_matched_nxt = prefix_matched_r + 3'd1;
          if (prefix_matched_nxt == sdef_pkg::TAG_LEN) begin
            line_mode_nxt     = sdef_pkg::MODE_DATA;
            space_checked_nxt = 1'b0;
            // separator in front of a further data line
            if (event_nonempty_r) begin
              r0 = '{kind: sdef_pkg::KIND_DATA, data: sdef_pkg::CH_LF};
              n_res  = 2'd1;
              n_data = 2'd1;
            end
          end
        end else begin
          line_mode_nxt = sdef_pkg::MODE_IGNORE;
        end
      end else if (line_mode_r == sdef_pkg::MODE_DATA) begin
        if (!space_checked_r) begin
          space_checked_nxt = 1'b1;
        end
        if (space_checked_r || data_byte != sdef_pkg::CH_SP) begin
          // a held return not followed by newline goes out first
          if (held_return_r) begin
            r0 = '{kind: sdef_pkg::KIND_DATA, data: sdef_pkg::CH_CR};
            n_res  = 2'd1;
            n_data = 2'd1;
            held_return_nxt = 1'b0;
          end
          if (data_byte == sdef_pkg::CH_CR) begin
            held_return_nxt = 1'b1;
          end else if (held_return_r) begin
            r1 = '{kind: sdef_pkg::KIND_DATA, data: data_byte};
            n_res  = 2'd2;
            n_data = 2'd2;
          end else begin
            r0 = '{kind: sdef_pkg::KIND_DATA, data: data_byte};
            n_res  = 2'd1;
            n_data = 2'd1;
          end
        end
      end
    end

    ev_sum = {1'b0, event_length_r} + {{(sdef_pkg::LEN_W-1){1'b0}}, n_data};
    if (n_data != 2'd0) begin
      event_nonempty_nxt = 1'b1;
    end
    if (stopped_r || total > {1'b0, byte_limit}) begin
      event_length_nxt = event_length_r;
    end else if (n_res == 2'd1 && r0.kind == sdef_pkg::KIND_EOE) begin
      event_length_nxt = '0;
    end else if (ev_sum > {1'b0, sdef_pkg::LEN_MAX}) begin
      event_length_nxt = sdef_pkg::LEN_MAX;
    end else begin
      event_length_nxt = ev_sum[sdef_pkg::LEN_W-1:0];
    end

    step.count = take ? n_res : 2'd0;
    step.res0  = r0;
    step.res1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r      <= sdef_pkg::MODE_PREFIX;
      prefix_matched_r <= 3'd0;
      space_checked_r  <= 1'b0;
      held_return_r    <= 1'b0;
      event_nonempty_r <= 1'b0;
      line_length_r    <= '0;
      event_length_r   <= '0;
      stopped_r        <= 1'b0;
    end else if (take) begin
      line_mode_r      <= line_mode_nxt;
      prefix_matched_r <= prefix_matched_nxt;
      space_checked_r  <= space_checked_nxt;
      held_return_r    <= held_return_nxt;
      event_nonempty_r <= event_nonempty_nxt;
      line_length_r    <= line_length_nxt;
      event_length_r   <= event_length_nxt;
      stopped_r        <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sdef_res_queue.sv
// four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps
`default_nettype none
module sdef_res_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  sdef_pkg::step_out_t push,
  output logic               room2,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte
);

  sdef_pkg::res_t slot_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign room2     = (count_r <= 3'd2);
  assign out_kind  = slot_r[rd_ptr_r].kind;
  assign out_byte  = slot_r[rd_ptr_r].data;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slot_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      slot_r[wr_ptr_r + 2'd1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire
